// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the merge block
// Define NO_ASSERTIONS to compile every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset
`define KWM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset
`define KWM_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define KWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define KWM_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Types, sizes and the heap ordering for the k-way sorted merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // Capacity and value width
  localparam int MAX_LISTS  = 16;
  localparam int VALUE_BITS = 32;

  // Fixed field widths of the ports
  localparam int STREAM_W = 4;
  localparam int CFG_W    = 5;

  // Derived sizes
  localparam int IDX_W   = $clog2(MAX_LISTS);
  localparam int CNT_W   = $clog2(MAX_LISTS + 1);
  localparam int KID_W   = IDX_W + 2;
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W + 1 : CFG_W + 1;
  localparam int ENTRY_W = STREAM_W + VALUE_BITS;

  // One heap entry: a stream head
  typedef struct packed {
    logic [STREAM_W-1:0]          stream;
    logic signed [VALUE_BITS-1:0] value;
  } head_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UPFIN,
    S_POST,
    S_TOP,
    S_LAST,
    S_DN0,
    S_DN1,
    S_DN2
  } state_e;

  // What the root read serves
  typedef enum logic {
    MODE_POP,
    MODE_REPLACE
  } top_mode_e;

  // Strict order: value first, lower stream wins a tie
  function automatic logic head_less(head_t a, head_t b);
    logic lt;
    if (a.value != b.value) begin
      lt = (a.value < b.value);
    end else begin
      lt = (a.stream < b.stream);
    end
    return lt;
  endfunction

  // Parent slot of a heap position
  function automatic logic [IDX_W-1:0] parent_of(logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] m;
    m = i - IDX_W'(1);
    return m >> 1;
  endfunction

endpackage

// ===== rtl/core/kwm_ram.sv =====
// ----------------------------------------------------------------------------
// kwm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/k_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Min-heap merge of up to MAX_LISTS ascending streams into one stream.
// ----------------------------------------------------------------------------
// Usage:
//   Write list_count through cfg_we_i/cfg_wdata_i while the block is idle.
//   A transfer happens at an edge where start is high and busy is low. First
//   load one item per stream (head value or end mark); the load that
//   completes the count pops the smallest head. From then on each transfer
//   must refill the stream named by the last source_stream_o; an item for
//   another stream is dropped. Each result shows for one cycle with
//   result_valid_o and cannot be stalled. last_result_o closes a merge,
//   all_empty_o flags a merge in which no stream had data.
// Flow:
//   A load climbs the heap (S_UP, S_UPFIN); an end mark or a load into an empty
//   heap goes straight to S_POST. A refill or end mark into an empty heap is
//   passed out at once; any other refill reads the root (S_TOP), which ends
//   there when the refill is the new minimum or the pop empties the heap, else
//   sifts down. The heap sits in one RAM with a single read port, so each
//   sift-down level costs two child reads and a compare. The final load adds its
//   pop. A result shows in the cycle right after the transfer for a refill into
//   an empty heap and after the root read (S_TOP) otherwise; the sift
//   keeps running behind busy.
// Reset: clears heap size, load count and phase; list_count returns to 16.
//   The RAM is not cleared: only entries below the heap size are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module k_way_sorted_merge
  import kwm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  // input items
  input  logic                         start,
  output logic                         busy,
  input  logic [STREAM_W-1:0]          stream_index_i,
  input  logic signed [VALUE_BITS-1:0] element_value_i,
  input  logic                         stream_done_i,
  // results
  output logic                         result_valid_o,
  output logic signed [VALUE_BITS-1:0] merged_value_o,
  output logic [STREAM_W-1:0]          source_stream_o,
  output logic                         last_result_o,
  output logic                         all_empty_o
);

  // Control state
  state_e              state_q, state_d;
  top_mode_e           mode_q, mode_d;
  logic                phase_q, phase_d;
  logic                end_q, end_d;
  logic [CNT_W-1:0]    heap_size_q, heap_size_d;
  logic [CNT_W-1:0]    loads_q, loads_d;
  logic [STREAM_W-1:0] refill_q, refill_d;
  logic [CFG_W-1:0]    list_count_q;
  logic [IDX_W-1:0]    idx_q, idx_d;

  // Moving entry and left child
  head_t x_q, x_d;
  head_t cl_q, cl_d;

  // Result registers
  logic                         result_valid_q, result_valid_d;
  logic signed [VALUE_BITS-1:0] merged_value_q, merged_value_d;
  logic [STREAM_W-1:0]          source_stream_q, source_stream_d;
  logic                         last_result_q, last_result_d;
  logic                         all_empty_q, all_empty_d;

  // RAM port
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  head_t              ram_wdata, rd;
  logic [ENTRY_W-1:0] ram_rdata;

  // Helpers
  logic [CNT_W-1:0] eff_count;
  logic [KID_W-1:0] left_idx, right_idx, size_ext;
  logic             left_ok, right_ok, right_wins;
  logic [IDX_W-1:0] up_parent, size_m1;
  head_t            child;
  logic [IDX_W-1:0] child_idx;
  head_t            in_head;

  assign rd      = ram_rdata;
  assign in_head = '{stream: stream_index_i, value: element_value_i};

  // Clamp the configured count into 1..MAX_LISTS
  always_comb begin
    if (list_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (CMP_W'(list_count_q) > CMP_W'(MAX_LISTS)) begin
      eff_count = CNT_W'(MAX_LISTS);
    end else begin
      eff_count = CNT_W'(list_count_q);
    end
  end

  // Child slots of the current position
  assign left_idx   = {1'b0, idx_q, 1'b1};
  assign right_idx  = left_idx + KID_W'(1);
  assign size_ext   = KID_W'(heap_size_q);
  assign left_ok    = (left_idx < size_ext);
  assign right_ok   = (right_idx < size_ext);
  assign right_wins = right_ok && head_less(rd, cl_q);
  assign child      = right_wins ? rd : cl_q;
  assign child_idx  = right_wins ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
  assign up_parent  = parent_of(idx_q);
  assign size_m1    = heap_size_q[IDX_W-1:0] - IDX_W'(1);

  // Next state, RAM accesses and results
  always_comb begin
    state_d         = state_q;
    mode_d          = mode_q;
    phase_d         = phase_q;
    end_d           = end_q;
    heap_size_d     = heap_size_q;
    loads_d         = loads_q;
    refill_d        = refill_q;
    idx_d           = idx_q;
    x_d             = x_q;
    cl_d            = cl_q;
    result_valid_d  = 1'b0;
    merged_value_d  = merged_value_q;
    source_stream_d = source_stream_q;
    last_result_d   = last_result_q;
    all_empty_d     = all_empty_q;
    ram_we          = 1'b0;
    ram_waddr       = idx_q;
    ram_wdata       = x_q;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d = in_head;
          if (!phase_q) begin
            // Load one stream head
            loads_d = loads_q + CNT_W'(1);
            end_d   = ({1'b0, loads_q} + (CNT_W+1)'(1)) >= {1'b0, eff_count};
            if (stream_done_i || heap_size_q == CNT_W'(MAX_LISTS)) begin
              state_d = S_POST;
            end else if (heap_size_q == '0) begin
              ram_we      = 1'b1;
              ram_waddr   = '0;
              ram_wdata   = in_head;
              heap_size_d = CNT_W'(1);
              state_d     = S_POST;
            end else begin
              idx_d       = heap_size_q[IDX_W-1:0];
              heap_size_d = heap_size_q + CNT_W'(1);
              ram_re      = 1'b1;
              ram_raddr   = parent_of(heap_size_q[IDX_W-1:0]);
              state_d     = S_UP;
            end
          end else if (stream_index_i == refill_q) begin
            if (heap_size_q == '0) begin
              // Nothing else waits: pass the refill straight out, or close
              result_valid_d  = 1'b1;
              source_stream_d = stream_index_i;
              all_empty_d     = 1'b0;
              if (stream_done_i) begin
                merged_value_d = '0;
                last_result_d  = 1'b1;
                heap_size_d    = '0;
                loads_d        = '0;
                phase_d        = 1'b0;
                refill_d       = '0;
              end else begin
                merged_value_d = element_value_i;
                last_result_d  = 1'b0;
              end
            end else begin
              mode_d    = stream_done_i ? MODE_POP : MODE_REPLACE;
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_TOP;
            end
          end
        end
      end

      S_UP: begin
        // Climb while the new entry beats its parent
        if (head_less(x_q, rd)) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = rd;
          idx_d     = up_parent;
          if (up_parent == '0) begin
            state_d = S_UPFIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = parent_of(up_parent);
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = x_q;
          state_d   = S_POST;
        end
      end

      S_UPFIN: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = x_q;
        state_d   = S_POST;
      end

      S_POST: begin
        // At the end of the load phase pop the first head, or close an empty merge
        if (end_q) begin
          if (heap_size_q == '0) begin
            result_valid_d  = 1'b1;
            merged_value_d  = '0;
            source_stream_d = '0;
            last_result_d   = 1'b1;
            all_empty_d     = 1'b1;
            heap_size_d     = '0;
            loads_d         = '0;
            phase_d         = 1'b0;
            refill_d        = '0;
            state_d         = S_IDLE;
          end else begin
            mode_d    = MODE_POP;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = S_TOP;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      S_TOP: begin
        result_valid_d = 1'b1;
        last_result_d  = 1'b0;
        all_empty_d    = 1'b0;
        phase_d        = 1'b1;
        if (mode_q == MODE_REPLACE && head_less(x_q, rd)) begin
          // Refill is the new minimum: heap stays as it is
          merged_value_d  = x_q.value;
          source_stream_d = x_q.stream;
          refill_d        = x_q.stream;
          state_d         = S_IDLE;
        end else if (mode_q == MODE_REPLACE) begin
          // Emit the root, sink the refill from the top
          merged_value_d  = rd.value;
          source_stream_d = rd.stream;
          refill_d        = rd.stream;
          idx_d           = '0;
          state_d         = S_DN0;
        end else begin
          // Emit the root, move the last entry up to sink
          merged_value_d  = rd.value;
          source_stream_d = rd.stream;
          refill_d        = rd.stream;
          heap_size_d     = heap_size_q - CNT_W'(1);
          if (heap_size_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = size_m1;
            state_d   = S_LAST;
          end
        end
      end

      S_LAST: begin
        x_d     = rd;
        idx_d   = '0;
        state_d = S_DN0;
      end

      S_DN0: begin
        if (left_ok) begin
          ram_re    = 1'b1;
          ram_raddr = left_idx[IDX_W-1:0];
          state_d   = S_DN1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = x_q;
          state_d   = S_IDLE;
        end
      end

      S_DN1: begin
        cl_d = rd;
        if (right_ok) begin
          ram_re    = 1'b1;
          ram_raddr = right_idx[IDX_W-1:0];
        end
        state_d = S_DN2;
      end

      S_DN2: begin
        // Swap down while the smaller child beats the moving entry
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        if (head_less(child, x_q)) begin
          ram_wdata = child;
          idx_d     = child_idx;
          state_d   = S_DN0;
        end else begin
          ram_wdata = x_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mode_q         <= MODE_POP;
      phase_q        <= 1'b0;
      end_q          <= 1'b0;
      heap_size_q    <= '0;
      loads_q        <= '0;
      refill_q       <= '0;
      list_count_q   <= CFG_W'(16);
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      mode_q         <= mode_d;
      phase_q        <= phase_d;
      end_q          <= end_d;
      heap_size_q    <= heap_size_d;
      loads_q        <= loads_d;
      refill_q       <= refill_d;
      result_valid_q <= result_valid_d;
      if (cfg_we_i) begin
        list_count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q           <= idx_d;
    x_q             <= x_d;
    cl_q            <= cl_d;
    merged_value_q  <= merged_value_d;
    source_stream_q <= source_stream_d;
    last_result_q   <= last_result_d;
    all_empty_q     <= all_empty_d;
  end

  // Heap storage
  kwm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_LISTS)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = result_valid_q;
  assign merged_value_o  = merged_value_q;
  assign source_stream_o = source_stream_q;
  assign last_result_o   = last_result_q;
  assign all_empty_o     = all_empty_q;

  // Checks
  `KWM_NEVER(a_size_bound, clk_i, rst_ni,
             heap_size_q > CNT_W'(MAX_LISTS), "heap size over capacity")
  `KWM_NEVER(a_ram_collide, clk_i, rst_ni,
             ram_we && ram_re && ram_waddr == ram_raddr, "RAM read and write hit one entry")
  `KWM_ASSERT(a_result_src, clk_i, rst_ni,
              result_valid_q |-> $past(state_q != S_IDLE || start), "result without work")
  `KWM_ASSERT(a_last_restart, clk_i, rst_ni,
              result_valid_q && last_result_q |-> !phase_q && heap_size_q == '0 && loads_q == '0,
              "closing result left merge state")
  `KWM_ASSERT(a_refill_track, clk_i, rst_ni,
              result_valid_q && !last_result_q |-> phase_q && refill_q == source_stream_q,
              "refill stream does not follow result")

endmodule

// ===== verif/tb_k_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// tb_k_way_sorted_merge
// Self-checking bench for the k-way sorted merge. Sorted streams are built in
// the bench and fed load by load, then refill by refill, always following the
// stream that the bench's own queue says is due next. Every transfer updates a
// software priority queue that predicts each merged result. Directed tests
// cover empty merges, a lone stream, value ties and a count lowered while
// loading; random merges follow with varied counts, value mixes, stray items
// and sender gaps.
// ----------------------------------------------------------------------------
module tb_k_way_sorted_merge
  import kwm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [STREAM_W-1:0]          stream;
    logic                         last;
    logic                         empty;
  } merge_out_t;

  // How stream values are drawn
  typedef enum int {
    VAL_FULL,
    VAL_TIGHT,
    VAL_EDGE
  } value_mix_e;

  localparam int SETTLE_CYCLES = 40;
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [CFG_W-1:0]             cfg_wdata_i = '0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [STREAM_W-1:0]          stream_index_i = '0;
  logic signed [VALUE_BITS-1:0] element_value_i = '0;
  logic                         stream_done_i = 1'b0;
  logic                         result_valid_o;
  logic signed [VALUE_BITS-1:0] merged_value_o;
  logic [STREAM_W-1:0]          source_stream_o;
  logic                         last_result_o;
  logic                         all_empty_o;

  // Predicted block state
  head_t               head_q[$];
  int                  heads_loaded = 0;
  bit                  merging = 1'b0;
  logic [STREAM_W-1:0] refill_id = '0;
  logic [CFG_W-1:0]    count_reg = CFG_W'(16);
  merge_out_t          merge_expect[$];

  // Stimulus bookkeeping
  logic signed [VALUE_BITS-1:0] stream_data[MAX_LISTS][$];
  int items_sent = 0;
  int idle_pct = 0;
  int mismatch_count = 0;

  k_way_sorted_merge i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .stream_index_i (stream_index_i),
    .element_value_i(element_value_i),
    .stream_done_i  (stream_done_i),
    .result_valid_o (result_valid_o),
    .merged_value_o (merged_value_o),
    .source_stream_o(source_stream_o),
    .last_result_o  (last_result_o),
    .all_empty_o    (all_empty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clamp the programmed count to the usable range
  function automatic int effective_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_LISTS) return MAX_LISTS;
    return count_reg;
  endfunction

  // Order heads by value, lower stream first on a tie
  function automatic bit head_precedes(head_t a, head_t b);
    if (a.value != b.value) return $signed(a.value) < $signed(b.value);
    return a.stream < b.stream;
  endfunction

  // Take the smallest head, or close the merge when none is left
  function automatic void pop_smallest(logic [STREAM_W-1:0] stream, bit empty);
    merge_out_t r;
    int best;
    best = 0;
    if (head_q.size() == 0) begin
      r.value  = '0;
      r.stream = empty ? '0 : stream;
      r.last   = 1'b1;
      r.empty  = empty;
      heads_loaded = 0;
      merging      = 1'b0;
      refill_id    = '0;
    end else begin
      for (int j = 1; j < head_q.size(); j++) begin
        if (head_precedes(head_q[j], head_q[best])) best = j;
      end
      r.value  = head_q[best].value;
      r.stream = head_q[best].stream;
      r.last   = 1'b0;
      r.empty  = 1'b0;
      refill_id = head_q[best].stream;
      merging   = 1'b1;
      head_q.delete(best);
    end
    merge_expect.push_back(r);
  endfunction

  // Advance the predicted state by one accepted transfer
  function automatic void predict_transfer(logic [STREAM_W-1:0] stream,
                                           logic signed [VALUE_BITS-1:0] value,
                                           logic done);
    head_t h;
    h.stream = stream;
    h.value  = value;
    if (!merging) begin
      if (!done && head_q.size() < MAX_LISTS) head_q.push_back(h);
      heads_loaded++;
      if (heads_loaded >= effective_count()) pop_smallest(stream, head_q.size() == 0);
    end else if (stream == refill_id) begin
      if (!done && head_q.size() < MAX_LISTS) head_q.push_back(h);
      pop_smallest(stream, 1'b0);
    end
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value(value_mix_e mix);
    case (mix)
      VAL_TIGHT: return $signed(VALUE_BITS'($urandom_range(6))) - 3;
      VAL_EDGE: begin
        case ($urandom_range(4))
          0:       return VALUE_MIN;
          1:       return VALUE_MIN + 1;
          2:       return VALUE_MAX - 1;
          3:       return VALUE_MAX;
          default: return '0;
        endcase
      end
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  // Hold start low until nothing is pending and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (merge_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] count);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_reg  = count;
  endtask

  // Offer one item, wait for the transfer, then predict it
  task automatic send_item(logic [STREAM_W-1:0] stream,
                           logic signed [VALUE_BITS-1:0] value, logic done);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    stream_index_i  <= stream;
    element_value_i <= value;
    stream_done_i   <= done;
    do @(posedge clk_i); while (busy);
    predict_transfer(stream, value, done);
  endtask

  // Send the next element of a stream, or its end mark once it runs dry
  task automatic feed_stream(logic [STREAM_W-1:0] stream);
    logic signed [VALUE_BITS-1:0] v;
    if (stream_data[stream].size() > 0) begin
      v = stream_data[stream].pop_front();
      send_item(stream, v, 1'b0);
    end else begin
      send_item(stream, VALUE_BITS'($urandom()), 1'b1);
    end
    items_sent++;
  endtask

  // Build fresh ascending streams
  task automatic fill_streams(value_mix_e mix, int max_len);
    int len;
    int p;
    logic signed [VALUE_BITS-1:0] v;
    for (int s = 0; s < MAX_LISTS; s++) begin
      stream_data[s].delete();
      len = $urandom_range(max_len);
      for (int n = 0; n < len; n++) begin
        v = pick_value(mix);
        p = 0;
        while (p < stream_data[s].size() && stream_data[s][p] <= v) p++;
        stream_data[s].insert(p, v);
      end
    end
  endtask

  // Refill whichever stream was popped last until the merge closes
  task automatic drain_merge(bit noisy);
    while (merging) begin
      if (noisy && $urandom_range(9) == 0) begin
        send_item(refill_id + STREAM_W'($urandom_range(1, MAX_LISTS - 1)),
                  VALUE_BITS'($urandom()), 1'($urandom_range(1)));
      end
      feed_stream(refill_id);
    end
  endtask

  // Load streams in shuffled order, then drain
  task automatic run_merge(bit noisy);
    int order[MAX_LISTS];
    int eff;
    int j;
    int tmp;
    int k;
    eff = effective_count();
    for (k = 0; k < MAX_LISTS; k++) order[k] = k;
    for (k = eff - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    k = 0;
    while (!merging && heads_loaded < eff) begin
      if (noisy && $urandom_range(9) == 0) begin
        feed_stream(STREAM_W'($urandom_range(MAX_LISTS - 1)));
      end else begin
        feed_stream(STREAM_W'(order[k % MAX_LISTS]));
      end
      k++;
      if (!merging && heads_loaded == 0) break;
    end
    drain_merge(noisy);
  endtask

  // Every stream empty: one closing result flagged empty
  task automatic test_all_empty();
    write_count(CFG_W'(2));
    fill_streams(VAL_FULL, 0);
    run_merge(1'b0);
  endtask

  // A count of zero acts as one; extremes on the top stream; a stray refill
  task automatic test_one_stream();
    write_count('0);
    fill_streams(VAL_FULL, 0);
    stream_data[MAX_LISTS-1].push_back(VALUE_MIN);
    stream_data[MAX_LISTS-1].push_back(VALUE_MAX);
    feed_stream(STREAM_W'(MAX_LISTS - 1));
    send_item(STREAM_W'(3), '0, 1'b0);
    drain_merge(1'b0);
  endtask

  // Equal values leave lower stream first
  task automatic test_ties();
    write_count(CFG_W'(3));
    fill_streams(VAL_FULL, 0);
    stream_data[0].push_back(5);
    stream_data[0].push_back(5);
    stream_data[1].push_back(5);
    stream_data[2].push_back(-1);
    stream_data[2].push_back(5);
    run_merge(1'b0);
  endtask

  // Lower the count below the loads seen: the next load starts the merge
  task automatic test_count_lowered();
    write_count(CFG_W'(6));
    fill_streams(VAL_FULL, 0);
    stream_data[0].push_back(10);
    stream_data[1].push_back(VALUE_MAX);
    feed_stream(STREAM_W'(0));
    feed_stream(STREAM_W'(1));
    feed_stream(STREAM_W'(2));
    write_count(CFG_W'(2));
    feed_stream(STREAM_W'(3));
    drain_merge(1'b0);
  endtask

  // Random merges with varied counts, value mixes and stray items
  task automatic test_random_merges(int idle, int quota);
    int target;
    value_mix_e mix;
    idle_pct = idle;
    target = items_sent + quota;
    write_count(CFG_W'(31));
    while (items_sent < target) begin
      case ($urandom_range(9))
        0:       write_count(CFG_W'($urandom_range(17, 31)));
        1:       write_count('0);
        2, 3, 4: write_count(CFG_W'($urandom_range(1, MAX_LISTS)));
        5:       write_count(CFG_W'(MAX_LISTS));
        default: ;
      endcase
      mix = value_mix_e'($urandom_range(2));
      fill_streams(mix, ($urandom_range(9) == 0) ? 12 : 4);
      run_merge(1'b1);
    end
  endtask

  // Compare each merged result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    merge_out_t want;
    if (rst_ni && result_valid_o) begin
      if (merge_expect.size() == 0) begin
        $error("unexpected result: merged_value %0d source_stream %0d",
               merged_value_o, source_stream_o);
        mismatch_count++;
      end else begin
        want = merge_expect.pop_front();
        if (merged_value_o !== want.value) begin
          $error("merged_value expected %0d got %0d", want.value, merged_value_o);
          mismatch_count++;
        end
        if (source_stream_o !== want.stream) begin
          $error("source_stream expected %0d got %0d", want.stream, source_stream_o);
          mismatch_count++;
        end
        if (last_result_o !== want.last) begin
          $error("last_result expected %0d got %0d", want.last, last_result_o);
          mismatch_count++;
        end
        if (all_empty_o !== want.empty) begin
          $error("all_empty expected %0d got %0d", want.empty, all_empty_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_all_empty();
    test_one_stream();
    test_ties();
    test_count_lowered();
    test_random_merges(0, 540);
    test_random_merges(86, 530);
    test_random_merges(26, 530);
    settle();
    if (mismatch_count == 0 && merge_expect.size() == 0) begin
      $display("tb_k_way_sorted_merge OK");
    end else begin
      $display("tb_k_way_sorted_merge NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10ms;
    $display("tb_k_way_sorted_merge NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/kwm_pkg.sv
rtl/core/kwm_ram.sv
rtl/core/k_way_sorted_merge.sv
verif/tb_k_way_sorted_merge.sv
